>>> rtl/rudi_pkg.sv
package rudi_pkg;

  // quotient bits kept by the distance divider; a larger quotient sets the overflow flag
  localparam int QW = 31;
  // magnitude of -org_z * 2^16
  localparam int NUM_W = 48;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd1;

  localparam logic [CFG_DATA_W-1:0] OBJECT_ID_RST    = 16'd0;
  localparam logic [CFG_DATA_W-1:0] MIN_DISTANCE_RST = 16'd7;

  // ray fields that ride along the divider
  typedef struct packed {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [30:0] best_t;
    logic [16:0] best_obj;
  } ray_ctx_t;

  typedef struct packed {
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
    ray_ctx_t      ctx;
  } div_out_t;

  typedef struct packed {
    logic [30:0] best_t;
    logic [16:0] best_obj;
    logic        hit;
  } result_t;

endpackage

>>> rtl/rudi_div.sv
module rudi_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [31:0]        in_oz,
  input  logic [31:0]        in_dz,
  input  rudi_pkg::ray_ctx_t in_ctx,
  output logic               out_vld,
  output rudi_pkg::div_out_t out_div
);
  import rudi_pkg::*;

  typedef struct packed {
    logic [31:0]   rem;
    logic [QW-1:0] quo;
    logic [QW-1:0] num;
    logic [31:0]   den;
    logic          neg;
    logic          ovf;
    ray_ctx_t      ctx;
  } div_stage_t;

  logic       vld_r [0:QW];
  div_stage_t st_r  [0:QW];

  logic [31:0]      oz_abs;
  logic [31:0]      dz_abs;
  logic [NUM_W-1:0] nmag;
  div_stage_t       st0_nxt;

  // entry stage: magnitudes, sign and the overflow test q >= 2^QW
  always_comb begin
    oz_abs = in_oz[31] ? (~in_oz + 32'd1) : in_oz;
    dz_abs = in_dz[31] ? (~in_dz + 32'd1) : in_dz;
    nmag   = {oz_abs, 16'd0};
    st0_nxt.rem = {{(32-(NUM_W-QW)){1'b0}}, nmag[NUM_W-1:QW]};
    st0_nxt.quo = '0;
    st0_nxt.num = nmag[QW-1:0];
    st0_nxt.den = dz_abs;
    // numerator -oz is negative when oz is positive
    st0_nxt.neg = ((in_oz != 32'd0) && !in_oz[31]) ^ in_dz[31];
    // zero divisor lands here too
    st0_nxt.ovf = (st0_nxt.rem >= dz_abs);
    st0_nxt.ctx = in_ctx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st0_nxt;
  end

  // one restoring step per stage, quotient bit QW-1-i in stage i
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [32:0] rs;
    logic [32:0] diff;
    logic        ge;
    div_stage_t  st_nxt;

    always_comb begin
      rs     = {st_r[i].rem, st_r[i].num[QW-1-i]};
      diff   = rs - {1'b0, st_r[i].den};
      ge     = (rs >= {1'b0, st_r[i].den});
      st_nxt = st_r[i];
      st_nxt.rem = ge ? diff[31:0] : rs[31:0];
      st_nxt.quo[QW-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      st_r[i+1] <= st_nxt;
    end
  end

  assign out_vld     = vld_r[QW];
  assign out_div.quo = st_r[QW].quo;
  assign out_div.neg = st_r[QW].neg;
  assign out_div.ovf = st_r[QW].ovf;
  assign out_div.ctx = st_r[QW].ctx;

endmodule

>>> rtl/rudi_point.sv
module rudi_point (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  rudi_pkg::div_out_t     in_div,
  input  logic [15:0]            object_id,
  input  logic [15:0]            min_distance,
  output logic                   out_vld,
  output rudi_pkg::result_t      out_res
);
  import rudi_pkg::*;

  // stage 1: products dir * t, distance window test
  logic               v1_r;
  logic signed [63:0] px_r, py_r;
  logic               t_ok_r;
  logic [30:0]        t1_r;
  logic [31:0]        ox1_r, oy1_r;
  logic [30:0]        bt1_r;
  logic [16:0]        bo1_r;

  logic signed [63:0] px_nxt, py_nxt;
  logic               t_ok_nxt;

  always_comb begin
    px_nxt   = $signed(in_div.ctx.dx) * $signed({1'b0, in_div.quo});
    py_nxt   = $signed(in_div.ctx.dy) * $signed({1'b0, in_div.quo});
    // negative or overflowed t never hits
    t_ok_nxt = !in_div.ovf && !in_div.neg &&
               (in_div.quo > {15'd0, min_distance}) &&
               (in_div.quo < in_div.ctx.best_t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    t_ok_r <= t_ok_nxt;
    t1_r   <= in_div.quo;
    ox1_r  <= in_div.ctx.ox;
    oy1_r  <= in_div.ctx.oy;
    bt1_r  <= in_div.ctx.best_t;
    bo1_r  <= in_div.ctx.best_obj;
  end

  // stage 2: floor shift, add origin, saturate
  logic        v2_r;
  logic [31:0] x2_r, y2_r;
  logic        t_ok2_r;
  logic [30:0] t2_r;
  logic [30:0] bt2_r;
  logic [16:0] bo2_r;

  logic [63:0] pxs, pys;
  logic [48:0] sx, sy;
  logic [31:0] x2_nxt, y2_nxt;

  always_comb begin
    pxs = px_r >>> 16;
    pys = py_r >>> 16;
    sx  = {{17{ox1_r[31]}}, ox1_r} + pxs[48:0];
    sy  = {{17{oy1_r[31]}}, oy1_r} + pys[48:0];
    if (sx[48:31] != {18{sx[48]}}) begin
      x2_nxt = sx[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      x2_nxt = sx[31:0];
    end
    if (sy[48:31] != {18{sy[48]}}) begin
      y2_nxt = sy[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      y2_nxt = sy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    x2_r    <= x2_nxt;
    y2_r    <= y2_nxt;
    t_ok2_r <= t_ok_r;
    t2_r    <= t1_r;
    bt2_r   <= bt1_r;
    bo2_r   <= bo1_r;
  end

  // stage 3: squares of the crossing point
  logic        v3_r;
  logic [63:0] sqx_r, sqy_r;
  logic        t_ok3_r;
  logic [30:0] t3_r;
  logic [30:0] bt3_r;
  logic [16:0] bo3_r;

  logic [31:0] ax, ay;

  always_comb begin
    ax = x2_r[31] ? (~x2_r + 32'd1) : x2_r;
    ay = y2_r[31] ? (~y2_r + 32'd1) : y2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sqx_r   <= {32'd0, ax} * {32'd0, ax};
    sqy_r   <= {32'd0, ay} * {32'd0, ay};
    t_ok3_r <= t_ok2_r;
    t3_r    <= t2_r;
    bt3_r   <= bt2_r;
    bo3_r   <= bo2_r;
  end

  // stage 4: disc test and record update
  logic    v4_r;
  result_t res_r;
  result_t res_nxt;
  logic [64:0] r2;
  logic        hit;

  always_comb begin
    r2  = {1'b0, sqx_r} + {1'b0, sqy_r};
    hit = t_ok3_r && (r2 <= 65'h1_0000_0000);
    if (hit) begin
      res_nxt.best_t   = t3_r;
      res_nxt.best_obj = {1'b0, object_id};
    end else begin
      res_nxt.best_t   = bt3_r;
      res_nxt.best_obj = bo3_r;
    end
    res_nxt.hit = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_vld = v4_r;
  assign out_res = res_r;

endmodule

>>> rtl/ray_unit_disc_intersect_top.sv
// Ray / unit-disc intersection, one ray per item, rays already in object space.
//
// Input channel: drive the ray on the in_ ports and raise start; the item is
// taken at a rising edge with start high and busy low. busy is high only
// while rst_n is low and for the cycle after it; otherwise an item may be
// given every cycle.
// Result channel: out_valid is high for one cycle with the updated closest
// hit record and out_disc_hit. Results come in input order; the receiver
// cannot stall, so nothing is held back. Throughput is one item per cycle.
// The pipeline is the distance divider (an entry stage plus one restoring
// step per quotient bit, 32 stages) followed by the point path (product,
// origin add, squares, disc test: 4 stages).
// Configuration: write object_id (index 0) and min_distance (index 1) on
// the cfg_ port; cfg_ready is always high and other indexes are ignored.
// Write only while no item is in flight.
// Reset: synchronous, active low; clears the pipeline valid bits and loads
// object_id = 0 and min_distance = 7.
module ray_unit_disc_intersect_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [31:0]                    in_org_x,
  input  logic [31:0]                    in_org_y,
  input  logic [31:0]                    in_org_z,
  input  logic [31:0]                    in_dir_x,
  input  logic [31:0]                    in_dir_y,
  input  logic [31:0]                    in_dir_z,
  input  logic [30:0]                    in_best_t_in,
  input  logic [16:0]                    in_best_object_in,
  output logic                           out_valid,
  output logic [30:0]                    out_best_t_out,
  output logic [16:0]                    out_best_object_out,
  output logic                           out_disc_hit,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rudi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rudi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rudi_pkg::*;

  logic                  busy_r;
  logic [CFG_DATA_W-1:0] object_id_r;
  logic [CFG_DATA_W-1:0] min_distance_r;

  logic     in_vld;
  ray_ctx_t in_ctx;
  logic     div_vld;
  div_out_t div_out;
  logic     pt_vld;
  result_t  pt_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_id_r    <= OBJECT_ID_RST;
      min_distance_r <= MIN_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OBJECT_ID:    object_id_r    <= cfg_data;
        CFG_MIN_DISTANCE: min_distance_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_vld          = start && !busy_r;
    in_ctx.ox       = in_org_x;
    in_ctx.oy       = in_org_y;
    in_ctx.dx       = in_dir_x;
    in_ctx.dy       = in_dir_y;
    in_ctx.best_t   = in_best_t_in;
    in_ctx.best_obj = in_best_object_in;
  end

  rudi_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_oz   (in_org_z),
    .in_dz   (in_dir_z),
    .in_ctx  (in_ctx),
    .out_vld (div_vld),
    .out_div (div_out)
  );

  rudi_point u_point (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (div_vld),
    .in_div       (div_out),
    .object_id    (object_id_r),
    .min_distance (min_distance_r),
    .out_vld      (pt_vld),
    .out_res      (pt_res)
  );

  assign out_valid           = pt_vld;
  assign out_best_t_out      = pt_res.best_t;
  assign out_best_object_out = pt_res.best_obj;
  assign out_disc_hit        = pt_res.hit;

endmodule

>>> test/tb_ray_unit_disc_intersect_top.sv
`timescale 1ns / 1ps

module tb_ray_unit_disc_intersect_top;
  import rudi_pkg::*;

  localparam int PIPE_LATENCY = 36;
  localparam int RAYS_PER_SETTING = 300;
  localparam int NUM_SETTINGS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic [30:0] T_NONE = 31'h7FFF_FFFF;
  localparam logic [16:0] OBJ_NONE = 17'h1_FFFF;

  typedef struct {
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        best_t;
    logic [16:0]        best_obj;
  } ray_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_org_x = '0;
  logic [31:0] in_org_y = '0;
  logic [31:0] in_org_z = '0;
  logic [31:0] in_dir_x = '0;
  logic [31:0] in_dir_y = '0;
  logic [31:0] in_dir_z = '0;
  logic [30:0] in_best_t_in = '0;
  logic [16:0] in_best_object_in = '0;
  logic out_valid;
  logic [30:0] out_best_t_out;
  logic [16:0] out_best_object_out;
  logic out_disc_hit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ray_t ray_q[$];
  result_t disc_record_q[$];
  ray_t cur_ray;
  int gap_left = 0;
  int burst_left = 0;
  int fail_count = 0;

  // shadow copy of the disc registers
  logic [15:0] disc_id;
  logic [15:0] min_dist;

  ray_unit_disc_intersect_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_org_x            (in_org_x),
    .in_org_y            (in_org_y),
    .in_org_z            (in_org_z),
    .in_dir_x            (in_dir_x),
    .in_dir_y            (in_dir_y),
    .in_dir_z            (in_dir_z),
    .in_best_t_in        (in_best_t_in),
    .in_best_object_in   (in_best_object_in),
    .out_valid           (out_valid),
    .out_best_t_out      (out_best_t_out),
    .out_best_object_out (out_best_object_out),
    .out_disc_hit        (out_disc_hit),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic result_t predict_disc_record(ray_t r);
    longint ox, oy, oz, dx, dy, dz, t, px, py;
    logic [63:0] ax, ay, r2;
    logic hit;
    result_t rec;
    ox = r.org_x;
    oy = r.org_y;
    oz = r.org_z;
    dx = r.dir_x;
    dy = r.dir_y;
    dz = r.dir_z;
    t = 0;
    hit = 1'b0;
    if (dz != 0) begin
      // divide truncates toward zero, shift floors
      t = sat32((-oz * 65536) / dz);
      px = sat32(ox + ((dx * t) >>> 16));
      py = sat32(oy + ((dy * t) >>> 16));
      ax = (px < 0) ? -px : px;
      ay = (py < 0) ? -py : py;
      r2 = ax * ax + ay * ay;
      hit = (r2 <= 64'h1_0000_0000) && (t > longint'(min_dist)) &&
            (t < longint'(r.best_t));
    end
    rec.best_t = hit ? t[30:0] : r.best_t;
    rec.best_obj = hit ? {1'b0, disc_id} : r.best_obj;
    rec.hit = hit;
    return rec;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      disc_id <= OBJECT_ID_RST;
      min_dist <= MIN_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OBJECT_ID:    disc_id <= cfg_data;
        CFG_MIN_DISTANCE: min_dist <= cfg_data;
        default: ;
      endcase
    end
  end

  // ray driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) disc_record_q.push_back(predict_disc_record(cur_ray));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left = gap_left - 1;
        end else if (ray_q.size() != 0) begin
          cur_ray = ray_q.pop_front();
          in_org_x <= cur_ray.org_x;
          in_org_y <= cur_ray.org_y;
          in_org_z <= cur_ray.org_z;
          in_dir_x <= cur_ray.dir_x;
          in_dir_y <= cur_ray.dir_y;
          in_dir_z <= cur_ray.dir_z;
          in_best_t_in <= cur_ray.best_t;
          in_best_object_in <= cur_ray.best_obj;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
            gap_left = 0;
          end else if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(10, 40);
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, 7);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid) begin
      if (disc_record_q.size() == 0) begin
        if (fail_count < 10) $display("unexpected result at %0t", $time);
        fail_count++;
      end else begin
        want = disc_record_q.pop_front();
        if (out_best_t_out !== want.best_t || out_best_object_out !== want.best_obj ||
            out_disc_hit !== want.hit) begin
          if (fail_count < 10)
            $display("mismatch at %0t: best_t %h/%h obj %h/%h hit %b/%b (exp/got)",
                     $time, want.best_t, out_best_t_out, want.best_obj,
                     out_best_object_out, want.hit, out_disc_hit);
          fail_count++;
        end
      end
    end
  end

  task automatic add_ray(input logic [31:0] ox, input logic [31:0] oy,
                         input logic [31:0] oz, input logic [31:0] dx,
                         input logic [31:0] dy, input logic [31:0] dz,
                         input logic [30:0] bt, input logic [16:0] bo);
    ray_t r;
    r.org_x = ox;
    r.org_y = oy;
    r.org_z = oz;
    r.dir_x = dx;
    r.dir_y = dy;
    r.dir_z = dz;
    r.best_t = bt;
    r.best_obj = bo;
    ray_q.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued ray went in and every record came back
  task automatic drain();
    int waited;
    waited = 0;
    do @(negedge clk); while (ray_q.size() != 0 || start);
    while (disc_record_q.size() != 0 && waited < 4 * PIPE_LATENCY) begin
      @(negedge clk);
      waited++;
    end
    if (disc_record_q.size() != 0) begin
      if (fail_count < 10) $display("%0d results never arrived", disc_record_q.size());
      fail_count += disc_record_q.size();
      disc_record_q.delete();
    end
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  initial begin
    ray_t r;
    longint tt, dzv, dxv, dyv, pxv, pyv;
    logic [15:0] set_id [NUM_SETTINGS];
    logic [15:0] set_min [NUM_SETTINGS];
    set_id = '{16'hFFFF, 16'h0001, 16'h8000, 16'h0000};
    set_min = '{16'h0000, 16'hFFFF, 16'h0800, 16'h0000};
    set_id[3] = 16'($urandom_range(0, 65535));
    set_min[3] = 16'($urandom_range(0, 65535));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed rays under reset settings (id 0, min distance 7)
    add_ray(0, 0, 0, 0, 0, 0, T_NONE, OBJ_NONE);
    add_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0,
            31'h0, 17'h0_FFFF);
    add_ray(0, 0, -Q_ONE, 0, 0, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(0, 0, -Q_ONE, 0, 0, Q_ONE, 31'h1_0000, 17'h0_1234);
    add_ray(0, 0, -Q_ONE, 0, 0, Q_ONE, 31'h1_0001, 17'h0_ABCD);
    add_ray(0, 0, -32'sd7, 0, 0, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(0, 0, -32'sd8, 0, 0, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(Q_ONE, 0, -Q_ONE, 0, 0, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(Q_ONE + 1, 0, -Q_ONE, 0, 0, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(32'h0000_B504, 32'h0000_B504, -Q_ONE, 0, 0, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(32'h0000_B505, 32'h0000_B505, -Q_ONE, 0, 0, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(0, 0, Q_ONE, 0, 0, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(0, 0, Q_ONE, 0, 0, -Q_ONE, T_NONE, 17'h0_FFFF);
    add_ray(0, 0, 32'h7FFF_FFFF, 0, 0, -32'sd1, T_NONE, OBJ_NONE);
    add_ray(0, 0, 32'h8000_0000, 0, 0, 32'h8000_0000, T_NONE, OBJ_NONE);
    add_ray(0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, T_NONE, OBJ_NONE);
    add_ray(0, 0, 32'h8000_0000, 0, 0, -32'sd1, T_NONE, OBJ_NONE);
    add_ray(32'h7FFF_FFFF, 0, -Q_ONE, 32'h7FFF_FFFF, 0, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(0, 32'h8000_0000, -Q_ONE, 0, 32'h8000_0000, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(0, 0, -32'sh8000, -32'sd1, -32'sd1, Q_ONE, T_NONE, OBJ_NONE);
    add_ray(0, 0, -Q_ONE, 0, 0, Q_ONE, 31'h0, 17'h0_FFFF);
    add_ray(0, 0, -32'sd1, 0, 0, 32'sd1, T_NONE, 17'h0_0000);
    drain();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      write_reg(CFG_OBJECT_ID, set_id[s]);
      write_reg(CFG_MIN_DISTANCE, set_min[s]);
      if (s == 1) begin
        // unmapped indexes must leave both registers alone
        write_reg(CFG_UNMAPPED_A, 16'h5A5A);
        write_reg(CFG_UNMAPPED_B, 16'hA5A5);
      end
      repeat (RAYS_PER_SETTING) begin
        if ($urandom_range(0, 4) != 0) begin
          // aim at a chosen point near the disc at a chosen distance
          dzv = longint'($urandom_range(1, 32'h4_0000));
          if ($urandom_range(0, 1) == 1) dzv = -dzv;
          case ($urandom_range(0, 9))
            0: tt = longint'(set_min[s]) + longint'($urandom_range(0, 4)) - 2;
            1: tt = -longint'($urandom_range(0, 32'h2_0000));
            default: tt = longint'($urandom_range(0, 32'h8_0000));
          endcase
          dxv = longint'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
          dyv = longint'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
          if ($urandom_range(0, 3) == 0) begin
            pxv = longint'($urandom_range(0, 32'h2_8000)) - 32'sh1_4000;
            pyv = longint'($urandom_range(0, 32'h2_8000)) - 32'sh1_4000;
          end else begin
            pxv = longint'($urandom_range(0, 32'h1_6000)) - 32'sh0_B000;
            pyv = longint'($urandom_range(0, 32'h1_6000)) - 32'sh0_B000;
          end
          r.org_x = 32'(pxv - ((dxv * tt) >>> 16));
          r.org_y = 32'(pyv - ((dyv * tt) >>> 16));
          r.org_z = 32'(-((tt * dzv) >>> 16));
          r.dir_x = 32'(dxv);
          r.dir_y = 32'(dyv);
          r.dir_z = 32'(dzv);
        end else begin
          r.org_x = $urandom;
          r.org_y = $urandom;
          r.org_z = $urandom;
          r.dir_x = $urandom;
          r.dir_y = $urandom;
          r.dir_z = ($urandom_range(0, 7) == 0) ? 32'sd0 : 32'($urandom);
        end
        case ($urandom_range(0, 3))
          0, 1: r.best_t = T_NONE;
          2: r.best_t = 31'($urandom_range(0, 32'h10_0000));
          default: r.best_t = 31'($urandom);
        endcase
        r.best_obj = ($urandom_range(0, 1) == 1) ? OBJ_NONE : 17'($urandom_range(0, 65535));
        ray_q.push_back(r);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
